@@ hdl/jse_pkg.sv @@
// shared types, constants and helpers for the json string escaper
package jse_pkg;

    localparam int JSE_Q_DEPTH = 4;
    localparam int JSE_Q_AW    = $clog2(JSE_Q_DEPTH);

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
        logic       error;
    } t_out_item;

    typedef enum logic [2:0] {
        K_NONE,
        K_PLAIN,
        K_ESC,
        K_UNIT1,
        K_UNIT2,
        K_ERROR,
        K_CLOSE
    } t_kind;

    // one classified request from the front to the back
    typedef struct packed {
        logic        open_q;
        t_kind       kind;
        logic [7:0]  ch;
        logic [15:0] unit_hi;
        logic [15:0] unit_lo;
    } t_cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'h0, nib};
        end else begin
            r = 8'h57 + {4'h0, nib};
        end
        return r;
    endfunction

    function automatic logic [3:0] body_len(input t_kind kind);
        logic [3:0] r;
        unique case (kind)
            K_NONE:  r = 4'd0;
            K_PLAIN: r = 4'd1;
            K_ESC:   r = 4'd2;
            K_UNIT1: r = 4'd6;
            K_UNIT2: r = 4'd12;
            K_ERROR: r = 4'd1;
            K_CLOSE: r = 4'd1;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/json_string_escaper_core.sv @@
// top level of the json string escaper: front, request queue and back
//
// the block turns a stream of string bytes, each string closed by an end item,
// into its double-quoted json form, one character per output request. the
// front takes one input request per cycle while the queue is not full,
// updates the utf-8 decode state and classifies the byte in the same cycle; the
// classified request goes into a four-entry queue. the back expands the head
// request at one character per cycle unless the output stalls, into an output
// register, so each item passes through the queue and that register before it
// is presented. requests per item: 1 for a plain byte, the closing quote or an
// error, 2 for a short escape, 6 for a \u00xx or a \uxxxx unit, 12 for a
// surrogate pair, plus 1 when the opening quote is due; continuation
// bytes that do not finish a sequence cost nothing. the back's expander sets
// the sustained rate: plain text moves at one byte per cycle unless the output
// stalls, and input ready drops only when the queue fills behind a run of
// escapes or a stalled output. the non-ascii escape flag (1 decodes utf-8 and
// escapes every multi-byte sequence as \u units) is written through
// i_cfg_we/i_cfg_wdata and is sampled only on bytes that start a sequence.
module json_string_escaper_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  jse_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output jse_pkg::t_out_item o_out_item
);

    // front to queue
    logic          push;
    jse_pkg::t_cmd push_cmd;
    logic          q_full;

    // queue to back
    logic          q_valid;
    jse_pkg::t_cmd q_head;
    logic          pop;

    // classification and utf-8 state
    jse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // decouples classification from expansion
    jse_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_head     (q_head),
        .i_pop      (pop)
    );

    // character expansion and output register
    jse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (q_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ hdl/jse_front.sv @@
// front end: accepts items, tracks utf-8 state and classifies each into a request
module jse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  jse_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output logic              o_push,
    output jse_pkg::t_cmd     o_cmd
);

    logic        r_esc_all;
    logic        r_open,   n_open;
    logic        r_failed, n_failed;
    logic [20:0] r_cp,     n_cp;
    logic [1:0]  r_bl,     n_bl;
    logic [1:0]  r_sl,     n_sl;

    logic          accept;
    logic [7:0]    b;
    logic [20:0]   cp_acc;
    logic [20:0]   cp_off;
    logic          bad_cp;
    jse_pkg::t_cmd cmd;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign b          = i_in_item.data_byte;
    assign cp_acc     = {r_cp[14:0], b[5:0]};
    assign cp_off     = cp_acc - 21'h010000;

    // range check on the completed code point
    always_comb begin
        unique case (r_sl)
            2'd1:    bad_cp = cp_acc < 21'h000080;
            2'd2:    bad_cp = (cp_acc < 21'h000800) ||
                              ((cp_acc >= 21'h00D800) && (cp_acc <= 21'h00DFFF));
            default: bad_cp = (cp_acc < 21'h010000) || (cp_acc > 21'h10FFFF);
        endcase
    end

    always_comb begin
        n_open   = r_open;
        n_failed = r_failed;
        n_cp     = r_cp;
        n_bl     = r_bl;
        n_sl     = r_sl;
        cmd      = '0;
        cmd.kind = jse_pkg::K_NONE;
        if (i_in_item.opcode == jse_pkg::OP_BYTE) begin
            if (!r_failed) begin
                cmd.open_q = !r_open;
                n_open     = 1'b1;
                if (r_bl != 2'd0) begin
                    if (b[7:6] != 2'b10) begin
                        cmd.kind = jse_pkg::K_ERROR;
                        n_failed = 1'b1;
                        n_cp     = '0;
                        n_bl     = '0;
                        n_sl     = '0;
                    end else begin
                        n_cp = cp_acc;
                        n_bl = r_bl - 2'd1;
                        if (r_bl == 2'd1) begin
                            n_cp = '0;
                            n_sl = '0;
                            if (bad_cp) begin
                                cmd.kind = jse_pkg::K_ERROR;
                                n_failed = 1'b1;
                            end else if (cp_acc < 21'h010000) begin
                                cmd.kind    = jse_pkg::K_UNIT1;
                                cmd.unit_hi = cp_acc[15:0];
                            end else begin
                                cmd.kind    = jse_pkg::K_UNIT2;
                                cmd.unit_hi = {6'b110110, cp_off[19:10]};
                                cmd.unit_lo = {6'b110111, cp_off[9:0]};
                            end
                        end
                    end
                end else if (r_esc_all && b[7]) begin
                    // lead byte of a multi-byte sequence, or an invalid byte
                    if (b >= 8'hC2 && b <= 8'hDF) begin
                        n_sl = 2'd1;
                        n_bl = 2'd1;
                        n_cp = {16'h0, b[4:0]};
                    end else if (b >= 8'hE0 && b <= 8'hEF) begin
                        n_sl = 2'd2;
                        n_bl = 2'd2;
                        n_cp = {17'h0, b[3:0]};
                    end else if (b >= 8'hF0 && b <= 8'hF4) begin
                        n_sl = 2'd3;
                        n_bl = 2'd3;
                        n_cp = {18'h0, b[2:0]};
                    end else begin
                        cmd.kind = jse_pkg::K_ERROR;
                        n_failed = 1'b1;
                        n_cp     = '0;
                        n_bl     = '0;
                        n_sl     = '0;
                    end
                end else begin
                    case (b) inside
                        jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH: begin
                            cmd.kind = jse_pkg::K_ESC;
                            cmd.ch   = b;
                        end
                        8'h08: begin
                            cmd.kind = jse_pkg::K_ESC;
                            cmd.ch   = jse_pkg::CH_B;
                        end
                        8'h0C: begin
                            cmd.kind = jse_pkg::K_ESC;
                            cmd.ch   = jse_pkg::CH_F;
                        end
                        8'h0A: begin
                            cmd.kind = jse_pkg::K_ESC;
                            cmd.ch   = jse_pkg::CH_N;
                        end
                        8'h0D: begin
                            cmd.kind = jse_pkg::K_ESC;
                            cmd.ch   = jse_pkg::CH_R;
                        end
                        8'h09: begin
                            cmd.kind = jse_pkg::K_ESC;
                            cmd.ch   = jse_pkg::CH_T;
                        end
                        default: begin
                            if (b < 8'h20) begin
                                cmd.kind    = jse_pkg::K_UNIT1;
                                cmd.unit_hi = {8'h00, b};
                            end else begin
                                cmd.kind = jse_pkg::K_PLAIN;
                                cmd.ch   = b;
                            end
                        end
                    endcase
                end
            end
        end else begin
            if (!r_failed) begin
                cmd.open_q = !r_open;
                cmd.kind   = (r_bl != 2'd0) ? jse_pkg::K_ERROR : jse_pkg::K_CLOSE;
            end
            n_open   = 1'b0;
            n_failed = 1'b0;
            n_cp     = '0;
            n_bl     = '0;
            n_sl     = '0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.open_q || (cmd.kind != jse_pkg::K_NONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_all <= 1'b0;
            r_open    <= 1'b0;
            r_failed  <= 1'b0;
            r_cp      <= '0;
            r_bl      <= '0;
            r_sl      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_esc_all <= i_cfg_wdata;
            end
            if (accept) begin
                r_open   <= n_open;
                r_failed <= n_failed;
                r_cp     <= n_cp;
                r_bl     <= n_bl;
                r_sl     <= n_sl;
            end
        end
    end

endmodule

@@ hdl/jse_queue.sv @@
// small request queue between front and back
module jse_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jse_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    output logic          o_valid,
    output jse_pkg::t_cmd o_head,
    input  logic          i_pop
);

    jse_pkg::t_cmd               r_mem [jse_pkg::JSE_Q_DEPTH];
    logic [jse_pkg::JSE_Q_AW-1:0] r_wp;
    logic [jse_pkg::JSE_Q_AW-1:0] r_rp;
    logic [jse_pkg::JSE_Q_AW:0]   r_cnt, n_cnt;

    assign o_full  = r_cnt == (jse_pkg::JSE_Q_AW+1)'(jse_pkg::JSE_Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !(i_pop && o_valid)) begin
            n_cnt = r_cnt + (jse_pkg::JSE_Q_AW+1)'(1);
        end else if (!i_push && i_pop && o_valid) begin
            n_cnt = r_cnt - (jse_pkg::JSE_Q_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + jse_pkg::JSE_Q_AW'(1);
            end
            if (i_pop && o_valid) begin
                r_rp <= r_rp + jse_pkg::JSE_Q_AW'(1);
            end
        end
    end

endmodule

@@ hdl/jse_back.sv @@
// back end: expands one request into characters and holds the output register
module jse_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  jse_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output jse_pkg::t_out_item o_out_item
);

    logic [3:0]         r_step, n_step;
    logic               r_out_valid;
    jse_pkg::t_out_item r_out_item;

    logic        emit_en;
    logic [3:0]  total;
    logic        is_last;
    logic [3:0]  j;
    logic [3:0]  k;
    logic [15:0] unit;
    logic [7:0]  ch;
    logic        err;

    assign emit_en = i_valid && (!r_out_valid || i_out_ready);
    assign total   = {3'b000, i_cmd.open_q} + jse_pkg::body_len(i_cmd.kind);
    assign is_last = r_step == (total - 4'd1);
    assign j       = r_step - {3'b000, i_cmd.open_q};
    assign unit    = (j >= 4'd6) ? i_cmd.unit_lo : i_cmd.unit_hi;
    assign k       = (j >= 4'd6) ? (j - 4'd6) : j;

    always_comb begin
        ch  = jse_pkg::CH_NUL;
        err = 1'b0;
        if (i_cmd.open_q && (r_step == 4'd0)) begin
            ch = jse_pkg::CH_QUOTE;
        end else begin
            case (i_cmd.kind) inside
                jse_pkg::K_PLAIN: ch = i_cmd.ch;
                jse_pkg::K_ESC:   ch = (j == 4'd0) ? jse_pkg::CH_BSLASH : i_cmd.ch;
                jse_pkg::K_UNIT1, jse_pkg::K_UNIT2: begin
                    case (k)
                        4'd0:    ch = jse_pkg::CH_BSLASH;
                        4'd1:    ch = jse_pkg::CH_U;
                        4'd2:    ch = jse_pkg::hex_char(unit[15:12]);
                        4'd3:    ch = jse_pkg::hex_char(unit[11:8]);
                        4'd4:    ch = jse_pkg::hex_char(unit[7:4]);
                        default: ch = jse_pkg::hex_char(unit[3:0]);
                    endcase
                end
                jse_pkg::K_ERROR: err = 1'b1;
                jse_pkg::K_CLOSE: ch = jse_pkg::CH_QUOTE;
                default:          ch = jse_pkg::CH_NUL;
            endcase
        end
    end

    always_comb begin
        n_step = r_step;
        if (emit_en) begin
            n_step = is_last ? 4'd0 : (r_step + 4'd1);
        end
    end

    assign o_pop       = emit_en && is_last;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (emit_en) begin
            r_out_item <= '{out_char: ch, last: is_last, error: err};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (emit_en) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/jse_checker.sv @@
// port-level checks for the json string escaper, bound to the top level
module jse_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input jse_pkg::t_out_item o_out_item
);

    // a waiting output request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output request dropped or changed while stalled");

    // an error ends the results of its item
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.error |-> o_out_item.last)
        else $error("error result not marked last");

    // nul never leaves raw, and only error results carry a zero character
    a_nul_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.out_char == jse_pkg::CH_NUL) == o_out_item.error))
        else $error("zero character and error flag disagree");

    // a presented output request is fully defined
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !$isunknown(o_out_item))
        else $error("output request carries unknown bits");

endmodule

bind json_string_escaper_core jse_checker u_jse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
